// ===== src/kt_pkg.sv =====
package kt_pkg;

  // Default longest word before it is cut off.
  localparam int MAX_WORD_DEF = 63;

  // Longest keyword, number of keywords, bytes per identifier chunk.
  localparam int KW_MAXLEN   = 10;
  localparam int KW_NUM      = 20;
  localparam int CHUNK_BYTES = 8;
  // Unsent word bytes held at once: a full keyword plus the byte that follows it.
  localparam int BUF_BYTES   = KW_MAXLEN + 1;

  // Token kinds.
  localparam logic [4:0] K_END   = 5'd0;
  localparam logic [4:0] K_SEMI  = 5'd1;
  localparam logic [4:0] K_EQ    = 5'd2;
  localparam logic [4:0] K_INT   = 5'd3;
  localparam logic [4:0] K_IDENT = 5'd4;
  localparam logic [4:0] K_KW0   = 5'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MINUS,
    ST_NUMBER,
    ST_WORD,
    ST_HALT
  } kt_state_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } kt_in_t;

  typedef struct packed {
    logic [4:0]         kind;
    logic signed [31:0] number;
    logic [63:0]        text_chunk;
    logic [3:0]         chunk_bytes;
    logic               last;
  } kt_out_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } kw_hit_t;

  // Keyword spellings, right-aligned: the first character sits in the highest used byte.
  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_NUM] = '{
    "exit", "fn", "call", "def", "int", "print", "str", "input", "neg", "inc",
    "dec", "sub", "add", "alloc", "sleep", "time", "isequal", "fopen", "fread",
    "filehandle"
  };

  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd4, 4'd2, 4'd4, 4'd3, 4'd3, 4'd5, 4'd3, 4'd5, 4'd3, 4'd3,
    4'd3, 4'd3, 4'd3, 4'd5, 4'd5, 4'd4, 4'd7, 4'd5, 4'd5, 4'd10
  };

  // Compares a word (first character in the lowest byte) with every keyword at once.
  function automatic kw_hit_t kw_lookup(input logic [8*KW_MAXLEN-1:0] word,
                                        input logic [3:0] len);
    kw_hit_t r;
    logic    eq;
    r = '0;
    for (int k = 0; k < KW_NUM; k++) begin
      eq = (len == KW_LEN[k]);
      for (int i = 0; i < KW_MAXLEN; i++) begin
        if (i < int'(KW_LEN[k])) begin
          eq &= (word[8*i +: 8] == KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8]);
        end
      end
      if (eq && !r.hit) begin
        r.hit  = 1'b1;
        r.kind = K_KW0 + 5'(k);
      end
    end
    return r;
  endfunction

endpackage

// ===== src/keyword_tokenizer.sv =====
// Streaming lexer: source text comes in one byte per request on the src channel, and tokens
// leave on the tok channel (end, ';', '=', 32-bit wrapping integers, twenty keywords, and
// identifiers split into 8-byte chunks with last set on the final chunk of each token).
// The block accepts a byte in every cycle while each byte causes at most one result and the
// tok channel takes it. A byte that completes one or more tokens causes up to three results;
// they wait in a three-entry output queue and leave it one per cycle while tok_ready is high.
// The next byte waits in the input register meanwhile and is processed in the cycle the last
// of them is sent. Once the end token has gone out, the block swallows further requests
// without results until reset. Words are held in an 11-byte window of unsent characters, so
// no memory and no clearing pass follow reset.
module keyword_tokenizer #(
  parameter int MAX_WORD = kt_pkg::MAX_WORD_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            src_valid,
  output logic            src_ready,
  input  kt_pkg::kt_in_t  src_data,
  output logic            tok_valid,
  input  logic            tok_ready,
  output kt_pkg::kt_out_t tok_data
);
  import kt_pkg::*;

  // The word length counter has to reach MAX_WORD itself.
  localparam int LW = $clog2(MAX_WORD + 1);
  localparam int BW = 8 * BUF_BYTES;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Input register: one byte waits here until its results fit into the output queue.
  logic   held;
  kt_in_t item;

  // Scanner state.
  kt_state_t      st, st_next;
  logic [31:0]    acc, acc_next;
  logic           neg, neg_next;
  logic [LW-1:0]  wlen, wlen_next;
  // Unsent word characters, the oldest in the lowest byte.
  logic [BW-1:0]  wbuf, wbuf_next;
  logic [3:0]     bcnt, bcnt_next;
  // Set once part of the current word has gone out, which rules out a keyword.
  logic           sent, sent_next;

  // Results of the byte in the input register, in emission order.
  kt_out_t    res [3];
  logic [1:0] res_n;

  // Output queue; entry 0 drives the tok channel.
  kt_out_t    rq [3];
  logic [1:0] rq_cnt;

  logic can_load;
  logic process;

  function automatic kt_out_t mk_res(input logic [4:0] kind, input logic [31:0] num,
                                     input logic [63:0] chunk, input logic [3:0] cnt,
                                     input logic last);
    kt_out_t r;
    r.kind        = kind;
    r.number      = num;
    r.text_chunk  = chunk;
    r.chunk_bytes = cnt;
    r.last        = last;
    return r;
  endfunction

  // Keeps the first cnt bytes of a chunk and clears the rest.
  function automatic logic [63:0] chunk_mask(input logic [63:0] bytes, input logic [3:0] cnt);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < CHUNK_BYTES; i++) begin
      if (4'(i) < cnt) begin
        r[8*i +: 8] = bytes[8*i +: 8];
      end
    end
    return r;
  endfunction

  function automatic logic [BW-1:0] put_byte(input logic [BW-1:0] buf_in,
                                             input logic [3:0] idx, input logic [7:0] b);
    logic [BW-1:0] r;
    r = buf_in;
    for (int i = 0; i < BUF_BYTES; i++) begin
      if (4'(i) == idx) begin
        r[8*i +: 8] = b;
      end
    end
    return r;
  endfunction

  // A new group of results may be loaded when the queue is empty or is sending its last entry.
  assign can_load  = (rq_cnt == 2'd0) || (rq_cnt == 2'd1 && tok_ready);
  assign process   = held && can_load;
  assign src_ready = !held || process;

  assign tok_valid = (rq_cnt != 2'd0);
  assign tok_data  = rq[0];

  // One scanner step for the held byte. The order of the sections below follows the order in
  // which results appear: a chunk from a growing word, the end of the current token, the
  // single-byte tokens that the same byte may start, and the end token last.
  always_comb begin : step_logic
    logic [7:0]  b;
    logic        fin;
    logic        is_dig;
    logic        is_ws;
    logic        is_wstart;
    logic        is_delim;
    logic [31:0] dval;
    logic        close_num;
    logic        close_word;
    logic        start;
    logic        begin_w;
    logic        hit_max;
    logic        do_halt;
    kw_hit_t     kw;

    st_next   = st;
    acc_next  = acc;
    neg_next  = neg;
    wlen_next = wlen;
    wbuf_next = wbuf;
    bcnt_next = bcnt;
    sent_next = sent;
    res       = '{default: '0};
    res_n     = 2'd0;

    b         = item.text_byte;
    fin       = item.end_of_input;
    is_dig    = b inside {[CH_ZERO:CH_NINE]};
    is_ws     = b inside {CH_SPACE, [CH_TAB:CH_CR]};
    is_wstart = b inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ], CH_SLASH, CH_DOT};
    is_delim  = is_ws || b == CH_SEMI || b == CH_EQ;
    dval      = {24'd0, b - CH_ZERO};
    kw        = '0;

    close_num  = 1'b0;
    close_word = 1'b0;
    start      = 1'b0;
    begin_w    = 1'b0;
    hit_max    = 1'b0;
    do_halt    = 1'b0;

    case (st)
      ST_IDLE: begin
        start = 1'b1;
      end
      ST_MINUS: begin
        // A minus only survives in front of a digit; before a word it is dropped.
        if (fin) begin
          do_halt = 1'b1;
        end else if (is_dig) begin
          acc_next = dval;
          st_next  = ST_NUMBER;
        end else begin
          neg_next = 1'b0;
          if (is_wstart) begin
            begin_w = 1'b1;
          end else begin
            do_halt = 1'b1;
          end
        end
      end
      ST_NUMBER: begin
        if (!fin && is_dig) begin
          acc_next = (acc << 3) + (acc << 1) + dval;
        end else begin
          close_num = 1'b1;
          start     = 1'b1;
        end
      end
      ST_WORD: begin
        if (!fin && !is_delim) begin
          if (int'(wlen) < MAX_WORD) begin
            wbuf_next = put_byte(wbuf, bcnt, b);
            bcnt_next = bcnt + 4'd1;
            wlen_next = wlen + LW'(1);
          end
          // Past keyword length, the oldest eight bytes go out as soon as more than eight wait.
          if (int'(wlen_next) > KW_MAXLEN && bcnt_next > 4'(CHUNK_BYTES)) begin
            res[res_n] = mk_res(K_IDENT, '0, wbuf_next[63:0], 4'(CHUNK_BYTES), 1'b0);
            res_n      = res_n + 2'd1;
            wbuf_next  = wbuf_next >> (8 * CHUNK_BYTES);
            bcnt_next  = bcnt_next - 4'(CHUNK_BYTES);
            sent_next  = 1'b1;
          end
          if (int'(wlen_next) >= MAX_WORD) begin
            hit_max = 1'b1;
          end
        end else begin
          close_word = 1'b1;
          start      = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Word end: a keyword token, or the unsent bytes as one or two identifier chunks.
    if (close_word || hit_max) begin
      kw = kw_lookup(wbuf_next[8*KW_MAXLEN-1:0], wlen_next[3:0]);
      if (!sent_next && int'(wlen_next) <= KW_MAXLEN && kw.hit) begin
        res[res_n] = mk_res(kw.kind, '0, '0, 4'd0, 1'b1);
        res_n      = res_n + 2'd1;
      end else if (bcnt_next > 4'(CHUNK_BYTES)) begin
        res[res_n] = mk_res(K_IDENT, '0, wbuf_next[63:0], 4'(CHUNK_BYTES), 1'b0);
        res_n      = res_n + 2'd1;
        res[res_n] = mk_res(K_IDENT, '0, chunk_mask(64'(wbuf_next >> (8 * CHUNK_BYTES)),
                            bcnt_next - 4'(CHUNK_BYTES)), bcnt_next - 4'(CHUNK_BYTES), 1'b1);
        res_n      = res_n + 2'd1;
      end else begin
        res[res_n] = mk_res(K_IDENT, '0, chunk_mask(wbuf_next[63:0], bcnt_next),
                            bcnt_next, 1'b1);
        res_n      = res_n + 2'd1;
      end
      st_next = ST_IDLE;
    end

    if (close_num) begin
      res[res_n] = mk_res(K_INT, neg ? (32'd0 - acc) : acc, '0, 4'd0, 1'b1);
      res_n      = res_n + 2'd1;
      neg_next   = 1'b0;
      st_next    = ST_IDLE;
    end

    // The byte that ended a token, or any byte between tokens, may start the next one.
    if (start) begin
      if (fin) begin
        do_halt = 1'b1;
      end else if (is_ws) begin
        st_next = ST_IDLE;
      end else if (b == CH_SEMI) begin
        res[res_n] = mk_res(K_SEMI, '0, '0, 4'd0, 1'b1);
        res_n      = res_n + 2'd1;
      end else if (b == CH_EQ) begin
        res[res_n] = mk_res(K_EQ, '0, '0, 4'd0, 1'b1);
        res_n      = res_n + 2'd1;
      end else if (b == CH_MINUS) begin
        neg_next = 1'b1;
        st_next  = ST_MINUS;
      end else begin
        neg_next = 1'b0;
        if (is_dig) begin
          acc_next = dval;
          st_next  = ST_NUMBER;
        end else if (is_wstart) begin
          begin_w = 1'b1;
        end else begin
          do_halt = 1'b1;
        end
      end
    end

    // A fresh word holds its first byte; one byte can neither fill it nor send a chunk.
    if (begin_w) begin
      wbuf_next = put_byte(wbuf_next, 4'd0, b);
      bcnt_next = 4'd1;
      wlen_next = LW'(1);
      sent_next = 1'b0;
      st_next   = ST_WORD;
    end

    if (do_halt) begin
      res[res_n] = mk_res(K_END, '0, '0, 4'd0, 1'b1);
      res_n      = res_n + 2'd1;
      st_next    = ST_HALT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= 1'b0;
      rq_cnt <= 2'd0;
      st     <= ST_IDLE;
      acc    <= '0;
      neg    <= 1'b0;
      wlen   <= '0;
      bcnt   <= '0;
      sent   <= 1'b0;
    end else begin
      if (src_ready) begin
        held <= src_valid;
      end
      if (process) begin
        st     <= st_next;
        acc    <= acc_next;
        neg    <= neg_next;
        wlen   <= wlen_next;
        bcnt   <= bcnt_next;
        sent   <= sent_next;
        rq_cnt <= res_n;
      end else if (tok_valid && tok_ready) begin
        rq_cnt <= rq_cnt - 2'd1;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      item <= src_data;
    end
    if (process) begin
      wbuf  <= wbuf_next;
      rq[0] <= res[0];
      rq[1] <= res[1];
      rq[2] <= res[2];
    end else if (tok_valid && tok_ready) begin
      rq[0] <= rq[1];
      rq[1] <= rq[2];
    end
  end

endmodule

// ===== src/kt_checker.sv =====
module kt_checker (
  input logic            clk,
  input logic            rst,
  input logic            tok_valid,
  input logic            tok_ready,
  input kt_pkg::kt_out_t tok_data
);
  import kt_pkg::*;

  // A result that is waiting keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(tok_data))
    else $error("result changed while stalled");

  // Nothing is left to send right after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !tok_valid)
    else $error("result pending after reset");

  // Right after the end token has been taken, no result is pending.
  a_halt: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_ready && tok_data.kind == K_END |=> !tok_valid)
    else $error("result after end token");

  // Only identifiers carry text, and every other token is a single result.
  a_plain: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_data.kind != K_IDENT |->
      tok_data.chunk_bytes == 4'd0 && tok_data.text_chunk == 64'd0 && tok_data.last)
    else $error("non-identifier token with text or without last");

  // Identifier chunks hold one to eight bytes, and only the final one may be short.
  a_chunk: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_data.kind == K_IDENT |->
      tok_data.chunk_bytes != 4'd0 && tok_data.chunk_bytes <= 4'd8 &&
      (tok_data.last || tok_data.chunk_bytes == 4'd8))
    else $error("bad identifier chunk size");

endmodule

bind keyword_tokenizer kt_checker u_kt_checker (.*);
